/* sv/mcf_pkg.sv */
// ----------------------------------------------------------------------------
// mcf_pkg: shared types and constants of the meter command framer
// Character codes, function codes, queue entry type and hex digit encoding.
// ----------------------------------------------------------------------------
package mcf_pkg;

    localparam logic [7:0] CH_SOH    = 8'h01;
    localparam logic [7:0] CH_STX    = 8'h02;
    localparam logic [7:0] CH_ETX    = 8'h03;
    localparam logic [7:0] CH_READ   = 8'h52;
    localparam logic [7:0] CH_WRITE  = 8'h57;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;

    localparam logic [1:0] FUNC_READ = 2'd0;
    localparam logic [1:0] FUNC_WHDR = 2'd1;
    localparam logic [1:0] FUNC_DATA = 2'd2;
    localparam logic [1:0] FUNC_END  = 2'd3;

    localparam logic [6:0] HDR_INNER = 7'd7;
    localparam logic [6:0] CNT_MAX   = 7'd127;
    localparam logic [3:0] LEN_MAX   = 4'hF;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // byte positions inside a queued command
    localparam logic [3:0] IDX_LAST_READ  = 4'd9;
    localparam logic [3:0] IDX_LAST_WHDR  = 4'd7;
    localparam logic [3:0] IDX_LAST_CLOSE = 4'd2;

    typedef enum logic [2:0] {
        K_READ,
        K_WHDR,
        K_DATA,
        K_CLOSE,
        K_ABORT
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] reg_id;
        logic [3:0]  len_nib;
        logic [7:0]  value;    // payload byte or closing BCC
    } t_cmd;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'h0, v};
        end else begin
            r = 8'h37 + {4'h0, v};
        end
        return r;
    endfunction

endpackage

/* sv/mcf_if.sv */
// ----------------------------------------------------------------------------
// mcf_if: valid/ready channels of the meter command framer
// Input channel carries commands, output channel carries frame bytes.
// ----------------------------------------------------------------------------
interface mcf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] reg_id;
    logic [7:0]  read_length;
    logic [7:0]  data_byte;

    modport source (output valid, output func, output reg_id, output read_length,
                    output data_byte, input ready);
    modport sink   (input valid, input func, input reg_id, input read_length,
                    input data_byte, output ready);
endinterface

interface mcf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_last;
    logic       abort;

    modport source (output valid, output out_byte, output frame_last, output abort,
                    input ready);
    modport sink   (input valid, input out_byte, input frame_last, input abort,
                    output ready);
endinterface

/* sv/mcf_front.sv */
// ----------------------------------------------------------------------------
// mcf_front: command intake and frame tracking
// Accepts commands, keeps the open write frame state and queues work.
// ----------------------------------------------------------------------------
module mcf_front import mcf_pkg::*; #(
    parameter int MAX_FRAME = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcf_in_if.sink     i_in,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam logic [7:0] LIMIT = 8'(MAX_FRAME);

    logic [7:0] r_bcc,      n_bcc;
    logic [6:0] r_count,    n_count;
    logic       r_in_write, n_in_write;
    logic       r_ovf,      n_ovf;

    logic       accept;
    logic [3:0] len_nib;
    logic [7:0] reg_x;
    logic [6:0] cnt_inc;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign len_nib    = (i_in.read_length > {4'h0, LEN_MAX}) ? 4'h0 : i_in.read_length[3:0];
    assign reg_x      = hex_digit(i_in.reg_id[15:12]) ^ hex_digit(i_in.reg_id[11:8])
                      ^ hex_digit(i_in.reg_id[7:4]) ^ hex_digit(i_in.reg_id[3:0]);
    assign cnt_inc    = (r_count < CNT_MAX) ? r_count + 7'd1 : r_count;

    always_comb begin
        n_bcc        = r_bcc;
        n_count      = r_count;
        n_in_write   = r_in_write;
        n_ovf        = r_ovf;
        o_push       = 1'b0;
        o_cmd.kind   = K_DATA;
        o_cmd.reg_id = i_in.reg_id;
        o_cmd.len_nib = len_nib;
        o_cmd.value  = i_in.data_byte;
        if (accept) begin
            unique case (i_in.func)
                FUNC_READ: begin
                    n_bcc      = 8'h00;
                    n_count    = 7'd0;
                    n_in_write = 1'b0;
                    n_ovf      = 1'b0;
                    o_push     = 1'b1;
                    o_cmd.kind = K_READ;
                    o_cmd.value = CH_READ ^ CH_STX ^ reg_x ^ hex_digit(len_nib) ^ CH_ETX;
                end
                FUNC_WHDR: begin
                    n_bcc      = CH_WRITE ^ CH_STX ^ reg_x ^ CH_LPAREN;
                    n_count    = HDR_INNER;
                    n_in_write = 1'b1;
                    n_ovf      = ({1'b0, HDR_INNER} > LIMIT);
                    o_push     = 1'b1;
                    o_cmd.kind = K_WHDR;
                end
                FUNC_DATA: begin
                    if (r_in_write) begin
                        n_bcc   = r_bcc ^ i_in.data_byte;
                        n_count = cnt_inc;
                        if ({1'b0, cnt_inc} > LIMIT) begin
                            n_ovf = 1'b1;
                        end
                        o_push  = 1'b1;
                    end
                end
                FUNC_END: begin
                    if (r_in_write) begin
                        o_push = 1'b1;
                        if (r_ovf || ({1'b0, r_count} + 8'd2 > LIMIT)) begin
                            o_cmd.kind = K_ABORT;
                        end else begin
                            o_cmd.kind  = K_CLOSE;
                            o_cmd.value = r_bcc ^ CH_RPAREN ^ CH_ETX;
                        end
                        n_bcc      = 8'h00;
                        n_count    = 7'd0;
                        n_in_write = 1'b0;
                        n_ovf      = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcc      <= 8'h00;
            r_count    <= 7'd0;
            r_in_write <= 1'b0;
            r_ovf      <= 1'b0;
        end else begin
            r_bcc      <= n_bcc;
            r_count    <= n_count;
            r_in_write <= n_in_write;
            r_ovf      <= n_ovf;
        end
    end

endmodule

/* sv/mcf_fifo.sv */
// ----------------------------------------------------------------------------
// mcf_fifo: short command queue between intake and serializer
// Register-based FIFO with simultaneous push and pop.
// ----------------------------------------------------------------------------
module mcf_fifo import mcf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd                 r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wptr, r_rptr;
    logic [FIFO_AW:0]     r_count;
    logic                 do_pop;

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/mcf_back.sv */
// ----------------------------------------------------------------------------
// mcf_back: frame byte serializer
// Walks each queued command byte by byte into a registered output stage.
// ----------------------------------------------------------------------------
module mcf_back import mcf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    mcf_out_if.source  o_out
);

    logic [3:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_abort;

    logic       advance;
    logic [3:0] last_idx;
    logic [7:0] sel_byte;
    logic       sel_last;
    logic       sel_abort;

    assign advance = !i_empty && (!r_valid || o_out.ready);
    assign o_pop   = advance && (r_idx == last_idx);

    always_comb begin
        last_idx  = 4'd0;
        sel_byte  = 8'h00;
        sel_last  = 1'b0;
        sel_abort = 1'b0;
        case (i_cmd.kind)
            K_READ, K_WHDR: begin
                last_idx = (i_cmd.kind == K_READ) ? IDX_LAST_READ : IDX_LAST_WHDR;
                case (r_idx)
                    4'd0:    sel_byte = CH_SOH;
                    4'd1:    sel_byte = (i_cmd.kind == K_READ) ? CH_READ : CH_WRITE;
                    4'd2:    sel_byte = CH_STX;
                    4'd3:    sel_byte = hex_digit(i_cmd.reg_id[15:12]);
                    4'd4:    sel_byte = hex_digit(i_cmd.reg_id[11:8]);
                    4'd5:    sel_byte = hex_digit(i_cmd.reg_id[7:4]);
                    4'd6:    sel_byte = hex_digit(i_cmd.reg_id[3:0]);
                    4'd7:    sel_byte = (i_cmd.kind == K_READ) ? hex_digit(i_cmd.len_nib)
                                                              : CH_LPAREN;
                    4'd8:    sel_byte = CH_ETX;
                    default: begin
                        sel_byte = i_cmd.value;
                        sel_last = 1'b1;
                    end
                endcase
            end
            K_DATA: begin
                sel_byte = i_cmd.value;
            end
            K_CLOSE: begin
                last_idx = IDX_LAST_CLOSE;
                case (r_idx)
                    4'd0:    sel_byte = CH_RPAREN;
                    4'd1:    sel_byte = CH_ETX;
                    default: begin
                        sel_byte = i_cmd.value;
                        sel_last = 1'b1;
                    end
                endcase
            end
            K_ABORT: begin
                sel_last  = 1'b1;
                sel_abort = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_valid <= 1'b1;
                r_idx   <= o_pop ? 4'd0 : r_idx + 4'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // payload stage holds until the next byte is loaded
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte  <= sel_byte;
            r_last  <= sel_last;
            r_abort <= sel_abort;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.out_byte   = r_byte;
    assign o_out.frame_last = r_last;
    assign o_out.abort      = r_abort;

endmodule

/* sv/meter_command_framer_bcc.sv */
// ----------------------------------------------------------------------------
// meter_command_framer_bcc: meter command frame builder with BCC
// Turns read, write-header, payload and end commands into wire bytes.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one command per transaction (func, reg_id, read_length,
//   data_byte); o_out carries one frame byte per transaction, with
//   frame_last on the BCC or abort byte and abort on an overflowed frame.
//   A read request yields 10 bytes, a write header 8, a payload byte 1 and
//   an end of write 3 (or a single abort byte). Commands with nothing to
//   send (payload or end with no open frame) are absorbed.
//   The intake tracks the frame and queues work in a 4-entry queue; the
//   serializer sends one byte per cycle while o_out is not stalled, so
//   payload streams at one command per cycle and a header goes out byte
//   by byte. A command's first byte passes the queue, then the registered
//   output stage. i_in.ready drops only while the queue is full, so commands
//   keep being taken while the output is stalled until the queue fills.
//   Reset empties the queue, closes any open frame and clears o_out.valid.
// ----------------------------------------------------------------------------
module meter_command_framer_bcc import mcf_pkg::*; #(
    parameter int MAX_FRAME = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcf_in_if.sink     i_in,
    mcf_out_if.source  o_out
);

    logic push, pop, full, empty;
    t_cmd push_cmd, head_cmd;

    mcf_front #(.MAX_FRAME(MAX_FRAME)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    mcf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    mcf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

/* sv/mcf_checker.sv */
// ----------------------------------------------------------------------------
// mcf_checker: port-level checks of the meter command framer
// Watches both channels and is bound to the top level.
// ----------------------------------------------------------------------------
module mcf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_frame_last,
    input logic       i_abort
);

    // an abort byte is always zero and closes its frame
    a_abort_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_abort |-> i_frame_last && (i_out_byte == 8'h00))
        else $error("abort byte not a zero closing byte");

    // leaving reset: queue empty, so input is ready and no byte is shown
    a_reset_idle: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> i_in_ready && !i_out_valid)
        else $error("block not idle after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_frame_last) && $stable(i_abort))
        else $error("stalled output transaction changed");

endmodule

bind meter_command_framer_bcc mcf_checker u_mcf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.out_byte),
    .i_frame_last (o_out.frame_last),
    .i_abort      (o_out.abort)
);
